[design/service_code_feistel_generator_top_defines.svh]
// ----------------------------------------------------------------------------
// Service code generator assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERVICE_CODE_FEISTEL_GENERATOR_TOP_DEFINES_SVH
`define SERVICE_CODE_FEISTEL_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication
`define SCFG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SCFG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/scfg_pkg.sv]
// ----------------------------------------------------------------------------
// scfg_pkg
// Types, constants and datapath functions of the service code generator.
// ----------------------------------------------------------------------------
package scfg_pkg;

  localparam int NIBBLES        = 12;
  localparam int ROUNDS         = 4;
  localparam int BIN_W          = 32;
  localparam int BCD_DIGITS     = 10;
  localparam int BCD_W          = 4 * BCD_DIGITS;
  localparam int BCD_STAGES     = 4;
  localparam int BITS_PER_STAGE = BIN_W / BCD_STAGES;

  // Register indexes on the configuration port
  localparam logic REG_KEY_LEVEL_ONE = 1'b0;
  localparam logic REG_KEY_LEVEL_TWO = 1'b1;

  // Key register reset values
  localparam logic [31:0] KEY_LEVEL_ONE_RST = 32'hC13A_F957;
  localparam logic [31:0] KEY_LEVEL_TWO_RST = 32'h9C67_D3A4;

  // Accepted key levels
  localparam logic [1:0] LEVEL_ONE = 2'd1;
  localparam logic [1:0] LEVEL_TWO = 2'd2;

  localparam logic [3:0] PAD_NIBBLE = 4'hF;

  typedef struct packed {
    logic [47:0] id_digits;
    logic [5:0]  digit_count;
    logic [1:0]  level;
  } in_beat_t;

  typedef struct packed {
    logic [BCD_W-1:0] code_low_bcd;
    logic [BCD_W-1:0] code_high_bcd;
    logic             error;
  } out_beat_t;

  // One slot of the binary-to-BCD pipeline
  typedef struct packed {
    logic [BCD_W-1:0] bcd_lo;
    logic [BCD_W-1:0] bcd_hi;
    logic [BIN_W-1:0] bin_lo;
    logic [BIN_W-1:0] bin_hi;
    logic             err;
  } conv_t;

  // Nibble S-box, high half
  function automatic logic [3:0] sub_high(logic [3:0] v);
    logic [3:0] r;
    unique case (v)
      4'd0:    r = 4'd9;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd7;
      4'd6:    r = 4'd5;
      4'd7:    r = 4'd3;
      4'd8:    r = 4'd1;
      4'd9:    r = 4'd0;
      default: r = v;
    endcase
    return r;
  endfunction

  // Nibble S-box, low half: decimal digits mirror, hex digits pass
  function automatic logic [3:0] sub_low(logic [3:0] v);
    logic [3:0] r;
    if (v <= 4'd9) begin
      r = 4'd9 - v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [7:0] sub_byte(logic [7:0] v);
    return {sub_high(v[7:4]), sub_low(v[3:0])};
  endfunction

  // Block build plus four Feistel rounds; returns {hi, lo}
  function automatic logic [2*BIN_W-1:0] cipher(in_beat_t d, logic [31:0] key);
    logic [3:0] nib [NIBBLES];
    logic [7:0] blk [8];
    logic [7:0] nl  [4];
    logic [7:0] kb;
    logic [7:0] f;
    logic [7:0] x;
    for (int k = 0; k < NIBBLES; k++) begin
      nib[k] = (k < int'(d.digit_count)) ? d.id_digits[4*k +: 4] : PAD_NIBBLE;
    end
    for (int m = 0; m < 6; m++) begin
      blk[7-m] = {nib[2*m], nib[2*m+1]};
    end
    blk[1] = 8'h00;
    x = 8'h00;
    for (int i = 1; i < 8; i++) begin
      x = x ^ blk[i];
    end
    blk[0] = x;
    for (int r = 0; r < ROUNDS; r++) begin
      kb = key[8*r +: 8];
      for (int i = 0; i < 4; i++) begin
        f = sub_byte(blk[i]) ^ kb;
        if (i % 2 == 1) begin
          f = ~f;
        end
        nl[i] = f ^ blk[i+4];
      end
      for (int i = 0; i < 4; i++) begin
        blk[i+4] = blk[i];
        blk[i]   = nl[i];
      end
    end
    return {blk[7], blk[6], blk[5], blk[4], blk[3], blk[2], blk[1], blk[0]};
  endfunction

  // One double-dabble step: add 3 to digits of 5 and up, then shift in a bit
  function automatic logic [BCD_W-1:0] dd_step(logic [BCD_W-1:0] bcd, logic b);
    logic [BCD_W-1:0] adj;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  // One pipeline stage worth of conversion, both halves side by side
  function automatic conv_t dd_stage(conv_t c);
    conv_t r;
    r = c;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      r.bcd_lo = dd_step(r.bcd_lo, r.bin_lo[BIN_W-1]);
      r.bin_lo = {r.bin_lo[BIN_W-2:0], 1'b0};
      r.bcd_hi = dd_step(r.bcd_hi, r.bin_hi[BIN_W-1]);
      r.bin_hi = {r.bin_hi[BIN_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic bcd_is_valid(logic [BCD_W-1:0] v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (v[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

[design/service_code_feistel_generator_top.sv]
// ----------------------------------------------------------------------------
// service_code_feistel_generator_top
// Turns an identity request into a two-part decimal service code.
// ----------------------------------------------------------------------------
// Takes one request beat per clock and returns one result beat per request,
// in order; the intake rate holds while the output side does not stall.
// The pipeline is an input register, a cipher stage (block build plus four
// Feistel rounds), three binary-to-BCD stages and the output register; each
// BCD stage, and the step into the output register, converts eight bits of
// both 32-bit halves. Stalls on out_ready back up stage by stage, so
// in_ready drops only when every stage is full. Bad levels or digit counts
// give error = 1 with all-zero codes. The user must write keys over the cfg
// port only while no request is in flight; the block does not enforce this.

`include "service_code_feistel_generator_top_defines.svh"

module service_code_feistel_generator_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  scfg_pkg::in_beat_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output scfg_pkg::out_beat_t   out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [31:0]           cfg_data
);

  localparam int NST = scfg_pkg::BCD_STAGES;

  logic [31:0]          key_one_r;
  logic [31:0]          key_two_r;
  logic                 in_v_r;
  scfg_pkg::in_beat_t   in_data_r;
  logic [NST-1:0]       v_r;
  scfg_pkg::conv_t      conv_r [NST];
  logic                 out_valid_r;
  scfg_pkg::out_beat_t  out_data_r;

  logic                 in_en;
  logic [NST-1:0]       en;
  logic                 out_en;
  logic                 req_err;
  logic [31:0]          key_sel;
  logic [63:0]          cip;
  scfg_pkg::conv_t      conv_nxt [NST];
  scfg_pkg::conv_t      last_conv;
  scfg_pkg::out_beat_t  out_data_nxt;

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_one_r <= scfg_pkg::KEY_LEVEL_ONE_RST;
      key_two_r <= scfg_pkg::KEY_LEVEL_TWO_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        scfg_pkg::REG_KEY_LEVEL_ONE: key_one_r <= cfg_data;
        scfg_pkg::REG_KEY_LEVEL_TWO: key_two_r <= cfg_data;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    out_en      = !out_valid_r || out_ready;
    en[NST-1]   = !v_r[NST-1] || out_en;
    for (int j = NST - 2; j >= 0; j--) begin
      en[j] = !v_r[j] || en[j+1];
    end
    in_en = !in_v_r || en[0];
  end

  assign in_ready = in_en;

  // Request check, key pick, cipher
  always_comb begin
    req_err = !((in_data_r.level == scfg_pkg::LEVEL_ONE) ||
                (in_data_r.level == scfg_pkg::LEVEL_TWO)) ||
              (in_data_r.digit_count == 6'd0) || in_data_r.digit_count[5];
    key_sel = (in_data_r.level == scfg_pkg::LEVEL_ONE) ? key_one_r : key_two_r;
    cip     = scfg_pkg::cipher(in_data_r, key_sel);
  end

  // Next values of the conversion stages
  always_comb begin
    conv_nxt[0].bcd_lo = '0;
    conv_nxt[0].bcd_hi = '0;
    conv_nxt[0].bin_lo = req_err ? '0 : cip[31:0];
    conv_nxt[0].bin_hi = req_err ? '0 : cip[63:32];
    conv_nxt[0].err    = req_err;
    for (int j = 1; j < NST; j++) begin
      conv_nxt[j] = scfg_pkg::dd_stage(conv_r[j-1]);
    end
    last_conv                  = scfg_pkg::dd_stage(conv_r[NST-1]);
    out_data_nxt.code_low_bcd  = last_conv.bcd_lo;
    out_data_nxt.code_high_bcd = last_conv.bcd_hi;
    out_data_nxt.error         = last_conv.err;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_en) begin
        in_v_r <= in_valid;
      end
      if (en[0]) begin
        v_r[0] <= in_v_r;
      end
      for (int j = 1; j < NST; j++) begin
        if (en[j]) begin
          v_r[j] <= v_r[j-1];
        end
      end
      if (out_en) begin
        out_valid_r <= v_r[NST-1];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_en) begin
      in_data_r <= in_data;
    end
    for (int j = 0; j < NST; j++) begin
      if (en[j]) begin
        conv_r[j] <= conv_nxt[j];
      end
    end
    if (out_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `SCFG_ASSERT_IMP(a_err_zero, out_valid_r && out_data_r.error,
    (out_data_r.code_low_bcd == '0) && (out_data_r.code_high_bcd == '0),
    "rejected request carries a nonzero code")
  `SCFG_ASSERT_IMP(a_bcd_digits, out_valid_r && !out_data_r.error,
    scfg_pkg::bcd_is_valid(out_data_r.code_low_bcd) &&
    scfg_pkg::bcd_is_valid(out_data_r.code_high_bcd),
    "result holds a digit above nine")
  `SCFG_ASSERT_NXT(a_in_capture, in_valid && in_ready, in_v_r,
    "accepted beat not held in the input register")
  `SCFG_ASSERT_IMP(a_full_stall, out_valid_r && !out_ready && (&v_r) && in_v_r,
    !in_ready, "input taken while every stage is full and blocked")
  `SCFG_ASSERT_IMP(a_err_bin_zero, v_r[0] && conv_r[0].err,
    (conv_r[0].bin_lo == '0) && (conv_r[0].bin_hi == '0),
    "rejected request enters conversion with nonzero value")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: service code generator testbench
// Drives requests over valid/ready, predicts each service code with an
// independent model of the block, checks every result beat in order, and
// walks the key registers through reset, all-zero, all-one and random values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 80;

  // Levels the block must reject
  localparam logic [1:0] LEVEL_NONE  = 2'd0;
  localparam logic [1:0] LEVEL_SPARE = 2'd3;

  // Nibble substitution tables, entry v at bits [4v+3:4v]
  localparam logic [63:0] SBOX_HIGH = 64'hFEDC_BA01_3578_6429;
  localparam logic [63:0] SBOX_LOW  = 64'hFEDC_BA01_2345_6789;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  scfg_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_ready;
  scfg_pkg::out_beat_t out_data;
  logic                cfg_we;
  logic                cfg_addr;
  logic [31:0]         cfg_data;

  // Traffic shaping; throttle_en is shared by the sender and the receiver
  bit throttle_en;
  bit sink_hold_req;

  // --------------------------------------------------------------------------
  // Scoreboard: key copy, code predictor and queue of expected codes
  // --------------------------------------------------------------------------
  class code_scoreboard;
    scfg_pkg::out_beat_t expected_codes[$];
    logic [31:0]         key_one;
    logic [31:0]         key_two;
    int                  errors;

    function new();
      key_one = scfg_pkg::KEY_LEVEL_ONE_RST;
      key_two = scfg_pkg::KEY_LEVEL_TWO_RST;
      errors  = 0;
    endfunction

    function void set_key(logic addr, logic [31:0] value);
      if (addr == scfg_pkg::REG_KEY_LEVEL_ONE) begin
        key_one = value;
      end else begin
        key_two = value;
      end
    endfunction

    function int pending();
      return expected_codes.size();
    endfunction

    function logic [scfg_pkg::BCD_W-1:0] to_decimal(logic [31:0] value);
      logic [scfg_pkg::BCD_W-1:0] digits;
      logic [31:0]                rest;
      rest = value;
      for (int i = 0; i < scfg_pkg::BCD_DIGITS; i++) begin
        digits[4*i +: 4] = 4'(rest % 10);
        rest = rest / 10;
      end
      return digits;
    endfunction

    function scfg_pkg::out_beat_t predict_code(scfg_pkg::in_beat_t req);
      scfg_pkg::out_beat_t code;
      logic [31:0]         key;
      logic [3:0]          nib [12];
      logic [7:0]          blk [8];
      logic [7:0]          left_next [4];
      logic [7:0]          sub;
      logic [7:0]          fval;
      logic [7:0]          par;
      code = '0;
      if ((req.level != scfg_pkg::LEVEL_ONE && req.level != scfg_pkg::LEVEL_TWO) ||
          req.digit_count == 6'd0 || req.digit_count >= 6'd32) begin
        code.error = 1'b1;
        return code;
      end
      key = (req.level == scfg_pkg::LEVEL_ONE) ? key_one : key_two;
      // Pad digits past the count, pack two per byte from byte 7 down
      for (int k = 0; k < 12; k++) begin
        nib[k] = (k < req.digit_count) ? req.id_digits[4*k +: 4]
                                       : scfg_pkg::PAD_NIBBLE;
      end
      for (int m = 0; m < 6; m++) begin
        blk[7-m] = {nib[2*m], nib[2*m+1]};
      end
      blk[1] = 8'h00;
      par = 8'h00;
      for (int i = 1; i < 8; i++) begin
        par ^= blk[i];
      end
      blk[0] = par;
      // Four rounds, one key byte each, lowest first
      for (int r = 0; r < 4; r++) begin
        for (int i = 0; i < 4; i++) begin
          sub  = {SBOX_HIGH[4*blk[i][7:4] +: 4], SBOX_LOW[4*blk[i][3:0] +: 4]};
          fval = sub ^ key[8*r +: 8];
          if (i % 2 == 1) begin
            fval = ~fval;
          end
          left_next[i] = fval ^ blk[i+4];
        end
        for (int i = 0; i < 4; i++) begin
          blk[i+4] = blk[i];
          blk[i]   = left_next[i];
        end
      end
      code.code_low_bcd  = to_decimal({blk[3], blk[2], blk[1], blk[0]});
      code.code_high_bcd = to_decimal({blk[7], blk[6], blk[5], blk[4]});
      return code;
    endfunction

    function void note_request(scfg_pkg::in_beat_t req);
      expected_codes.push_back(predict_code(req));
    endfunction

    task report_mismatch(string what, logic [scfg_pkg::BCD_W-1:0] got,
                         logic [scfg_pkg::BCD_W-1:0] want);
      errors++;
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    task check_code(scfg_pkg::out_beat_t got);
      scfg_pkg::out_beat_t want;
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected beat", got.code_low_bcd, '0);
        return;
      end
      want = expected_codes.pop_front();
      if (got.code_low_bcd !== want.code_low_bcd) begin
        report_mismatch("code_low_bcd", got.code_low_bcd, want.code_low_bcd);
      end
      if (got.code_high_bcd !== want.code_high_bcd) begin
        report_mismatch("code_high_bcd", got.code_high_bcd, want.code_high_bcd);
      end
      if (got.error !== want.error) begin
        report_mismatch("error", 40'(got.error), 40'(want.error));
      end
    endtask
  endclass

  code_scoreboard sb;

  service_code_feistel_generator_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready = 1'b0;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (throttle_en && $urandom_range(0, 6) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Result beat monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_code(out_data);
    end
  end

  function automatic scfg_pkg::in_beat_t make_request(logic [47:0] digits,
                                                      logic [5:0] count,
                                                      logic [1:0] level);
    scfg_pkg::in_beat_t req;
    req.id_digits   = digits;
    req.digit_count = count;
    req.level       = level;
    return req;
  endfunction

  // Mostly well-formed requests, some rejected ones
  function automatic scfg_pkg::in_beat_t random_request();
    scfg_pkg::in_beat_t req;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      for (int k = 0; k < 12; k++) begin
        req.id_digits[4*k +: 4] = 4'($urandom_range(0, 9));
      end
    end else begin
      req.id_digits = {16'($urandom), 32'($urandom)};
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      req.digit_count = 6'($urandom_range(1, 12));
    end else if (pick < 85) begin
      req.digit_count = 6'($urandom_range(13, 31));
    end else if (pick < 93) begin
      req.digit_count = 6'($urandom_range(32, 63));
    end else begin
      req.digit_count = 6'($urandom_range(0, 63));
    end
    if ($urandom_range(0, 99) < 88) begin
      req.level = ($urandom_range(0, 1) == 0) ? scfg_pkg::LEVEL_ONE : scfg_pkg::LEVEL_TWO;
    end else begin
      req.level = 2'($urandom_range(0, 3));
    end
    return req;
  endfunction

  function automatic int next_gap();
    if (throttle_en && $urandom_range(0, 5) == 0) begin
      return $urandom_range(1, 12);
    end
    return 0;
  endfunction

  // Offer one request beat after an optional gap, return once it is taken
  task automatic send_request(scfg_pkg::in_beat_t req, int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  // Stop offering and wait until every expected code has come back
  task automatic wait_for_codes();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(logic addr, logic [31:0] value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_key(addr, value);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      send_request(random_request(), next_gap());
    end
  endtask

  // Field extremes, hex nibbles, short identities and every reject reason
  task automatic send_directed();
    send_request(make_request(48'h0000_0000_0000, 6'd12, scfg_pkg::LEVEL_ONE), next_gap());
    send_request(make_request(48'hFFFF_FFFF_FFFF, 6'd12, scfg_pkg::LEVEL_TWO), next_gap());
    send_request(make_request(48'h1234_5678_9012, 6'd12, scfg_pkg::LEVEL_ONE), next_gap());
    send_request(make_request(48'h9999_9999_9999, 6'd31, scfg_pkg::LEVEL_TWO), next_gap());
    send_request(make_request(48'hABCD_EF01_2345, 6'd12, scfg_pkg::LEVEL_ONE), next_gap());
    send_request(make_request(48'h5555_5555_5555, 6'd1,  scfg_pkg::LEVEL_ONE), next_gap());
    send_request(make_request(48'hAAAA_AAAA_AAAA, 6'd11, scfg_pkg::LEVEL_TWO), next_gap());
    send_request(make_request(48'h0123_4567_8901, 6'd6,  scfg_pkg::LEVEL_ONE), next_gap());
    send_request(make_request(48'h3141_5926_5358, 6'd13, scfg_pkg::LEVEL_TWO), next_gap());
    send_request(make_request(48'h1234_5678_9012, 6'd0,  scfg_pkg::LEVEL_ONE), next_gap());
    send_request(make_request(48'h1234_5678_9012, 6'd32, scfg_pkg::LEVEL_TWO), next_gap());
    send_request(make_request(48'h1234_5678_9012, 6'd63, scfg_pkg::LEVEL_ONE), next_gap());
    send_request(make_request(48'h1234_5678_9012, 6'd12, LEVEL_NONE), next_gap());
    send_request(make_request(48'h1234_5678_9012, 6'd12, LEVEL_SPARE), next_gap());
    send_request(make_request(48'h0000_0000_0000, 6'd0,  LEVEL_NONE), next_gap());
    send_request(make_request(48'hFFFF_FFFF_FFFF, 6'd63, LEVEL_SPARE), next_gap());
    send_request(make_request(48'h0000_0000_0000, 6'd1,  scfg_pkg::LEVEL_TWO), next_gap());
    send_request(make_request(48'h8765_4321_0987, 6'd2,  scfg_pkg::LEVEL_TWO), next_gap());
    send_request(make_request(48'hFEDC_BA98_7654, 6'd31, scfg_pkg::LEVEL_ONE), next_gap());
    send_request(make_request(48'h0000_0000_0000, 6'd31, scfg_pkg::LEVEL_TWO), next_gap());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_addr      = scfg_pkg::REG_KEY_LEVEL_ONE;
    cfg_data      = '0;
    throttle_en   = 1'b1;
    sink_hold_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset keys
    send_directed();
    wait_for_codes();

    // All-zero keys
    write_key(scfg_pkg::REG_KEY_LEVEL_ONE, 32'h0000_0000);
    write_key(scfg_pkg::REG_KEY_LEVEL_TWO, 32'h0000_0000);
    send_random(70);
    wait_for_codes();

    // All-one keys; receiver holds off while the sender keeps pushing
    write_key(scfg_pkg::REG_KEY_LEVEL_ONE, 32'hFFFF_FFFF);
    write_key(scfg_pkg::REG_KEY_LEVEL_TWO, 32'hFFFF_FFFF);
    throttle_en   = 1'b0;
    sink_hold_req = 1'b1;
    send_random(40);
    throttle_en = 1'b1;
    send_random(40);
    // sender pause until the pipeline is empty
    wait_for_codes();
    send_random(40);
    wait_for_codes();

    // Random keys
    write_key(scfg_pkg::REG_KEY_LEVEL_ONE, $urandom);
    write_key(scfg_pkg::REG_KEY_LEVEL_TWO, $urandom);
    send_random(130);
    wait_for_codes();

    write_key(scfg_pkg::REG_KEY_LEVEL_TWO, $urandom);
    write_key(scfg_pkg::REG_KEY_LEVEL_ONE, $urandom);
    send_random(90);
    wait_for_codes();

    // Back to reset keys, full rate on both sides
    write_key(scfg_pkg::REG_KEY_LEVEL_ONE, scfg_pkg::KEY_LEVEL_ONE_RST);
    write_key(scfg_pkg::REG_KEY_LEVEL_TWO, scfg_pkg::KEY_LEVEL_TWO_RST);
    throttle_en = 1'b0;
    send_random(110);
    wait_for_codes();

    while (sb.pending() > 0) begin
      sb.report_mismatch("missing beat", '0, sb.expected_codes.pop_front().code_low_bcd);
    end
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/scfg_pkg.sv
design/service_code_feistel_generator_top.sv
tb/tb_top.sv
